@@ sv/pdks_pkg.sv @@
// Shared types and constants of the PD kinematic steering controller.
package pdks_pkg;

	// Field widths
	localparam int unsigned ERR_W = 16;
	localparam int unsigned SPEED_W = 17;
	localparam int unsigned GAIN_W = 24;
	localparam int unsigned WBASE_W = 13;
	localparam int unsigned LIMIT_W = 14;
	localparam int unsigned RATE_W = 10;
	localparam int unsigned STEER_W = 15;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 24;

	// Multiplier operand width and quotient length of the final division
	localparam int unsigned MUL_W = 32;
	localparam int unsigned QUOT_W = 16;
	localparam int unsigned DIV_CNT_W = $clog2(QUOT_W);

	// round(2^40 * 18000 / (65536000 * pi)): Q16 rad to centidegrees, Q40
	localparam logic [26:0] RAD_TO_CDEG_K = 27'd96126367;
	localparam logic [SPEED_W-1:0] MIN_SPEED_MM_S = 17'd1000;
	localparam logic [QUOT_W-1:0] BIG_MAG = 16'd16384;
	localparam logic [63:0] PROD_LIMIT = 64'h4000_0000_0000_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PROP_GAIN  = 3'd0,
		CFG_DERIV_GAIN = 3'd1,
		CFG_WHEELBASE  = 3'd2,
		CFG_MAX_STEER  = 3'd3,
		CFG_RATE       = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		LIM_NONE = 2'd0,
		LIM_MAX  = 2'd1,
		LIM_MIN  = 2'd2
	} lim_status_t;

	typedef struct packed {
		logic [GAIN_W-1:0]  prop_gain;
		logic [GAIN_W-1:0]  deriv_gain;
		logic [WBASE_W-1:0] wheelbase_mm;
		logic [LIMIT_W-1:0] max_steer_centideg;
		logic [RATE_W-1:0]  control_rate_hz;
	} cfg_regs_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_A,
		ST_MUL_B1,
		ST_MUL_B2,
		ST_SUM_Y,
		ST_ABS_Y,
		ST_MUL_P0,
		ST_MUL_P1,
		ST_SUM_P,
		ST_CHECK,
		ST_MUL_K0,
		ST_MUL_K1,
		ST_SUM_K,
		ST_DIV,
		ST_FINISH
	} ctrl_state_t;

	typedef enum logic [3:0] {
		OP_IDLE,
		OP_LOAD,
		OP_MUL_A,
		OP_MUL_B1,
		OP_MUL_B2,
		OP_SUM_Y,
		OP_ABS_Y,
		OP_MUL_P0,
		OP_MUL_P1,
		OP_SUM_P,
		OP_CHECK,
		OP_MUL_K0,
		OP_MUL_K1,
		OP_SUM_K,
		OP_DIV,
		OP_EMIT
	} dp_op_t;

	typedef struct packed {
		logic fresh;
		logic big;
		logic out_free;
	} dp_status_t;

endpackage

@@ sv/pd_kinematic_steering_control_top.sv @@
// Top level of the PD kinematic steering controller: config registers and channels.
//
//  channel   | dir | handshake             | payload
//  ----------+-----+-----------------------+------------------------------------------
//  s_axis    | in  | s_axis_tvalid/tready  | tdata: error_mm, speed; tuser: path_fresh
//  m_axis    | out | m_axis_tvalid/tready  | tdata: steering; tuser: limit_status
//  cfg       | in  | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// A fresh-path request runs through 12 steps on the shared 32x32 multiplier and
// accumulator, 16 steps of the bit-serial divider and one to emit, which waits while
// the output register is full. A stale-path request goes straight to the emit step;
// a saturated demand skips the conversion multiplies and the divider. One request is in
// work at a time; the output register holds a result while the next request is accepted.
// Reset clears the error ring and pointer and loads the register defaults.
module pd_kinematic_steering_control_top #(
	parameter int unsigned HISTORY_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // [15:0] lookahead_error_mm, [32:16] speed_mm_s
	input  logic        s_axis_tuser,   // [0] path_fresh
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [14:0] steering_centideg
	output logic [1:0]  m_axis_tuser,   // [1:0] limit_status
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [pdks_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pdks_pkg::CFG_DATA_W-1:0] cfg_data
);
	import pdks_pkg::*;

	cfg_regs_t  cfg_q;
	dp_op_t     op;
	dp_status_t st;
	logic signed [STEER_W-1:0] out_steer;
	lim_status_t out_status;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain <= 24'd65536;
			cfg_q.deriv_gain <= 24'd0;
			cfg_q.wheelbase_mm <= 13'd3000;
			cfg_q.max_steer_centideg <= 14'd1500;
			cfg_q.control_rate_hz <= 10'd20;
		end else if (cfg_valid) begin
			// unknown indexes are dropped
			unique case (cfg_index)
				CFG_PROP_GAIN:  cfg_q.prop_gain <= cfg_data[GAIN_W-1:0];
				CFG_DERIV_GAIN: cfg_q.deriv_gain <= cfg_data[GAIN_W-1:0];
				CFG_WHEELBASE:  cfg_q.wheelbase_mm <= cfg_data[WBASE_W-1:0];
				CFG_MAX_STEER:  cfg_q.max_steer_centideg <= cfg_data[LIMIT_W-1:0];
				CFG_RATE:       cfg_q.control_rate_hz <= cfg_data[RATE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	pdks_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.st       (st),
		.op       (op)
	);

	pdks_dpath #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.op         (op),
		.st         (st),
		.cfg        (cfg_q),
		.in_fresh   (s_axis_tuser),
		.in_error   ($signed(s_axis_tdata[ERR_W-1:0])),
		.in_speed   (s_axis_tdata[ERR_W +: SPEED_W]),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_steer  (out_steer),
		.out_status (out_status)
	);

	assign m_axis_tdata = {1'b0, out_steer};
	assign m_axis_tuser = out_status;

endmodule

@@ sv/pdks_ctrl.sv @@
// Datapath sequencer: one command per cycle unless the output is full.
module pdks_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  pdks_pkg::dp_status_t st,
	output pdks_pkg::dp_op_t     op
);
	import pdks_pkg::*;

	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(QUOT_W - 1);

	ctrl_state_t state_q, state_d;
	logic [DIV_CNT_W-1:0] div_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (state_q == ST_DIV) begin
			div_cnt_q <= div_cnt_q + 1'b1;
		end else begin
			div_cnt_q <= '0;
		end
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		op = OP_IDLE;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					op = OP_LOAD;
					state_d = ST_MUL_A;
				end
			end
			ST_MUL_A: begin
				// stale path: nothing to compute, result is zero
				if (st.fresh) begin
					op = OP_MUL_A;
					state_d = ST_MUL_B1;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_MUL_B1: begin
				op = OP_MUL_B1;
				state_d = ST_MUL_B2;
			end
			ST_MUL_B2: begin
				op = OP_MUL_B2;
				state_d = ST_SUM_Y;
			end
			ST_SUM_Y: begin
				op = OP_SUM_Y;
				state_d = ST_ABS_Y;
			end
			ST_ABS_Y: begin
				op = OP_ABS_Y;
				state_d = ST_MUL_P0;
			end
			ST_MUL_P0: begin
				op = OP_MUL_P0;
				state_d = ST_MUL_P1;
			end
			ST_MUL_P1: begin
				op = OP_MUL_P1;
				state_d = ST_SUM_P;
			end
			ST_SUM_P: begin
				op = OP_SUM_P;
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				op = OP_CHECK;
				state_d = st.big ? ST_FINISH : ST_MUL_K0;
			end
			ST_MUL_K0: begin
				op = OP_MUL_K0;
				state_d = ST_MUL_K1;
			end
			ST_MUL_K1: begin
				op = OP_MUL_K1;
				state_d = ST_SUM_K;
			end
			ST_SUM_K: begin
				op = OP_SUM_K;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				op = OP_DIV;
				if (div_cnt_q == DIV_LAST) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				// hold until the output register can take the result
				if (st.out_free) begin
					op = OP_EMIT;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && in_valid) |=> (state_q == ST_MUL_A))
		else $error("accepted request did not start the sequence");

	a_div_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_DIV) |-> (div_cnt_q == '0))
		else $error("division counter running outside division");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_EMIT) |-> st.out_free)
		else $error("result emitted into a full output register");

endmodule

@@ sv/pdks_dpath.sv @@
// Datapath: error ring, shared 32x32 multiplier, accumulator, divider, output register.
module pdks_dpath #(
	parameter int unsigned HISTORY_DEPTH = 4
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  pdks_pkg::dp_op_t                      op,
	output pdks_pkg::dp_status_t                  st,
	input  pdks_pkg::cfg_regs_t                   cfg,
	input  logic                                  in_fresh,
	input  logic signed [pdks_pkg::ERR_W-1:0]     in_error,
	input  logic [pdks_pkg::SPEED_W-1:0]          in_speed,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [pdks_pkg::STEER_W-1:0]   out_steer,
	output pdks_pkg::lim_status_t                 out_status
);
	import pdks_pkg::*;

	localparam int unsigned PTR_W = $clog2(HISTORY_DEPTH);
	localparam int unsigned EH_W = ERR_W + PTR_W;
	localparam int unsigned DEN_W = SPEED_W + PTR_W;
	localparam int unsigned DR_W = ERR_W + RATE_W;
	localparam int unsigned TA_W = GAIN_W + EH_W;
	localparam int unsigned TB_W = GAIN_W + DR_W;
	localparam int unsigned YM_W = ((TA_W > TB_W) ? TA_W : TB_W) + 1;
	localparam int unsigned YS_W = YM_W + 1;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(HISTORY_DEPTH - 1);

	// ring and control state
	logic signed [ERR_W-1:0] hist_q [HISTORY_DEPTH];
	logic [PTR_W-1:0]        ptr_q;
	logic                    fresh_q;
	logic                    out_valid_q;

	// working registers of the current request
	logic signed [ERR_W-1:0]   e_q;
	logic signed [ERR_W:0]     dlt_q;
	logic [DEN_W-1:0]          den_q;
	logic [2*MUL_W-1:0]        prod_q;
	logic [2*MUL_W-1:0]        acc_q;
	logic signed [YS_W-1:0]    y_q;
	logic [YM_W-1:0]           ymag_q;
	logic                      yneg_q;
	logic                      big_q;
	logic [DEN_W-1:0]          rem_q;
	logic [QUOT_W-1:0]         num_q;
	logic [QUOT_W-1:0]         quot_q;
	logic signed [STEER_W-1:0] steer_q;
	lim_status_t               status_q;

	logic signed [ERR_W-1:0] evicted;
	logic [ERR_W-1:0]        e_mag;
	logic [EH_W-1:0]         e_scaled;
	logic [ERR_W:0]          dlt_abs;
	logic [SPEED_W-1:0]      speed_sel;
	logic [MUL_W-1:0]        mul_a, mul_b;
	logic [2*MUL_W-1:0]      product;
	logic signed [YS_W-1:0]  ta_ext, tb_ext, y_abs;
	logic                    big_cond;
	logic [2*MUL_W-1:0]      nsum;
	logic [DEN_W:0]          rem_sh, rem_diff;
	logic                    rem_geq;
	logic [QUOT_W-1:0]       mag;
	logic [STEER_W-1:0]      lim15;
	logic signed [STEER_W-1:0] res_steer;
	lim_status_t             res_status;

	assign evicted = hist_q[ptr_q];
	assign e_mag = e_q[ERR_W-1] ? ERR_W'(-e_q) : ERR_W'(e_q);
	assign e_scaled = EH_W'(e_mag) * EH_W'(HISTORY_DEPTH);
	assign dlt_abs = dlt_q[ERR_W] ? (ERR_W+1)'(-dlt_q) : (ERR_W+1)'(dlt_q);
	assign speed_sel = (in_speed > MIN_SPEED_MM_S) ? in_speed : MIN_SPEED_MM_S;

	// operand select of the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (op)
			OP_MUL_A: begin
				mul_a = MUL_W'(cfg.prop_gain);
				mul_b = MUL_W'(e_scaled);
			end
			OP_MUL_B1: begin
				mul_a = MUL_W'(dlt_abs[ERR_W-1:0]);
				mul_b = MUL_W'(cfg.control_rate_hz);
			end
			OP_MUL_B2: begin
				mul_a = MUL_W'(cfg.deriv_gain);
				mul_b = MUL_W'(prod_q[DR_W-1:0]);
			end
			OP_MUL_P0: begin
				mul_a = ymag_q[MUL_W-1:0];
				mul_b = MUL_W'(cfg.wheelbase_mm);
			end
			OP_MUL_P1: begin
				mul_a = MUL_W'(ymag_q[YM_W-1:MUL_W]);
				mul_b = MUL_W'(cfg.wheelbase_mm);
			end
			OP_MUL_K0: begin
				mul_a = acc_q[MUL_W-1:0];
				mul_b = MUL_W'(RAD_TO_CDEG_K);
			end
			OP_MUL_K1: begin
				mul_a = MUL_W'(acc_q[2*MUL_W-2:MUL_W]);
				mul_b = MUL_W'(RAD_TO_CDEG_K);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign product = (2*MUL_W)'(mul_a) * (2*MUL_W)'(mul_b);

	assign ta_ext = $signed(YS_W'(prod_q[TA_W-1:0]));
	assign tb_ext = $signed(YS_W'(prod_q[TB_W-1:0]));
	assign y_abs = y_q[YS_W-1] ? -y_q : y_q;

	// demand too large: product above 2^62 or integer quotient at least 2^28
	assign big_cond = (acc_q > PROD_LIMIT) || (acc_q >= ((2*MUL_W)'(den_q) << 28));

	// floor((P*K + 2^39*D) / 2^32) from the two partial products
	assign nsum = prod_q + (2*MUL_W)'(acc_q[2*MUL_W-1:MUL_W]);

	assign rem_sh = {rem_q, num_q[QUOT_W-1]};
	assign rem_geq = rem_sh >= (DEN_W+1)'(den_q);
	assign rem_diff = rem_sh - (DEN_W+1)'(den_q);

	// clamp and sign of the command
	assign mag = big_q ? BIG_MAG : quot_q;
	assign lim15 = STEER_W'(cfg.max_steer_centideg);
	always_comb begin
		res_steer = '0;
		res_status = LIM_NONE;
		if (fresh_q) begin
			if (mag > QUOT_W'(cfg.max_steer_centideg)) begin
				res_steer = yneg_q ? $signed(-lim15) : $signed(lim15);
				res_status = yneg_q ? LIM_MIN : LIM_MAX;
			end else begin
				res_steer = yneg_q ? $signed(-mag[STEER_W-1:0]) : $signed(mag[STEER_W-1:0]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HISTORY_DEPTH; i++) begin
				hist_q[i] <= '0;
			end
			ptr_q <= '0;
			fresh_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (op == OP_LOAD) begin
				fresh_q <= in_fresh;
				if (in_fresh) begin
					hist_q[ptr_q] <= in_error;
					ptr_q <= (ptr_q == PTR_LAST) ? '0 : ptr_q + 1'b1;
				end else begin
					// stale path: drop the history, keep the pointer
					for (int i = 0; i < HISTORY_DEPTH; i++) begin
						hist_q[i] <= '0;
					end
				end
			end
			if (op == OP_EMIT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (op)
			OP_LOAD: begin
				e_q <= in_error;
				dlt_q <= $signed({in_error[ERR_W-1], in_error}) -
					$signed({evicted[ERR_W-1], evicted});
				den_q <= DEN_W'(speed_sel) * DEN_W'(HISTORY_DEPTH);
				big_q <= 1'b0;
				yneg_q <= 1'b0;
			end
			OP_MUL_A, OP_MUL_B2, OP_MUL_P0, OP_MUL_K0: begin
				prod_q <= product;
			end
			OP_MUL_B1: begin
				prod_q <= product;
				y_q <= e_q[ERR_W-1] ? -ta_ext : ta_ext;
			end
			OP_SUM_Y: begin
				y_q <= y_q + (dlt_q[ERR_W] ? -tb_ext : tb_ext);
			end
			OP_ABS_Y: begin
				ymag_q <= y_abs[YM_W-1:0];
				yneg_q <= y_q[YS_W-1];
			end
			OP_MUL_P1: begin
				prod_q <= product;
				acc_q <= prod_q;
			end
			OP_SUM_P: begin
				acc_q <= acc_q + {prod_q[MUL_W-1:0], {MUL_W{1'b0}}};
			end
			OP_CHECK: begin
				big_q <= big_cond;
			end
			OP_MUL_K1: begin
				prod_q <= product;
				acc_q <= prod_q + ((2*MUL_W)'(den_q) << 39);
			end
			OP_SUM_K: begin
				rem_q <= nsum[8+QUOT_W +: DEN_W];
				num_q <= nsum[8 +: QUOT_W];
				quot_q <= '0;
			end
			OP_DIV: begin
				rem_q <= rem_geq ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
				num_q <= {num_q[QUOT_W-2:0], 1'b0};
				quot_q <= {quot_q[QUOT_W-2:0], rem_geq};
			end
			OP_EMIT: begin
				steer_q <= res_steer;
				status_q <= res_status;
			end
			default: begin
			end
		endcase
	end

	assign st.fresh = fresh_q;
	assign st.big = big_cond;
	assign st.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_steer = steer_q;
	assign out_status = status_q;

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_q <= PTR_LAST)
		else $error("history pointer beyond ring depth");

	a_stale_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_EMIT && !fresh_q) |=> (steer_q == '0 && status_q == LIM_NONE))
		else $error("stale path produced a nonzero command");

endmodule
